>>> sv/trmc_pkg.sv
// types and constants shared by the tick rate mode controller
`default_nettype none
package trmc_pkg;

	localparam int CMD_W    = 3;
	localparam int AMOUNT_W = 16;
	localparam int MEAN_W   = 20;
	localparam int STEPS_W  = 16;
	localparam int MODE_W   = 3;

	localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FREEZE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RESET   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FORWARD = 3'd3;
	localparam logic [CMD_W-1:0] CMD_WARP    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SLOW    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_ACCEL   = 3'd6;

	typedef enum logic [MODE_W-1:0] {
		MODE_NORMAL  = 3'd0,
		MODE_FROZEN  = 3'd1,
		MODE_FORWARD = 3'd2,
		MODE_WARP    = 3'd3,
		MODE_SLOW    = 3'd4,
		MODE_ACCEL   = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		KIND_TICK,
		KIND_FREEZE,
		KIND_RESET,
		KIND_FORWARD,
		KIND_WARP,
		KIND_SLOW,
		KIND_ACCEL,
		KIND_IGNORE
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [AMOUNT_W-1:0] amount;
		logic [MEAN_W-1:0]   mean;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WARP,
		BK_MOD,
		BK_SLOW_END
	} back_st_t;

endpackage
`default_nettype wire

>>> sv/trmc_if.sv
// handshake channels for input words and result words
`default_nettype none
interface trmc_in_if;
	import trmc_pkg::*;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [AMOUNT_W-1:0] amount;
	logic [MEAN_W-1:0]   mean_tick_us;

	modport source (output valid, command, amount, mean_tick_us, input ready);
	modport sink   (input valid, command, amount, mean_tick_us, output ready);
endinterface

interface trmc_out_if;
	import trmc_pkg::*;
	logic               valid;
	logic               ready;
	logic [STEPS_W-1:0] steps_to_run;
	logic               accepted;
	logic               finished;
	logic [MODE_W-1:0]  mode_now;

	modport source (output valid, steps_to_run, accepted, finished, mode_now, input ready);
	modport sink   (input valid, steps_to_run, accepted, finished, mode_now, output ready);
endinterface
`default_nettype wire

>>> sv/trmc_front.sv
// front end: accepts words, decodes the command and queues them
`default_nettype none
module trmc_front
	import trmc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	trmc_in_if.sink    items,
	output head_t      head,
	input  wire logic  pop
);

	item_t       q_mem [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        do_pop;
	kind_t       kind;

	always_comb begin
		unique case (items.command)
			CMD_TICK:    kind = KIND_TICK;
			CMD_FREEZE:  kind = KIND_FREEZE;
			CMD_RESET:   kind = KIND_RESET;
			CMD_FORWARD: kind = KIND_FORWARD;
			CMD_WARP:    kind = KIND_WARP;
			CMD_SLOW:    kind = KIND_SLOW;
			CMD_ACCEL:   kind = KIND_ACCEL;
			default:     kind = KIND_IGNORE;
		endcase
	end

	assign items.ready = (count_q != 2'd2);
	assign push        = items.valid && items.ready;
	assign do_pop      = pop && (count_q != 2'd0);
	assign head.valid  = (count_q != 2'd0);
	assign head.item   = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= '{kind: kind, amount: items.amount, mean: items.mean_tick_us};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> sv/trmc_back.sv
// back end: mode state, warp budget count, slow phase modulo and result register
`default_nettype none
module trmc_back
	import trmc_pkg::*;
#(
	parameter int MAX_WARP_STEPS = 8,
	parameter int WARP_BUDGET_US = 45000
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  head_t      head,
	output logic       pop,
	trmc_out_if.source results
);

	localparam int CW    = $clog2(MAX_WARP_STEPS + 1);
	localparam int BW    = $clog2(WARP_BUDGET_US + 1);
	localparam int SUM_W = ((BW > MEAN_W) ? BW : MEAN_W) + 1;
	localparam logic [CW-1:0]    MAX_K  = CW'(MAX_WARP_STEPS);
	localparam logic [SUM_W-1:0] BUDGET = SUM_W'(WARP_BUDGET_US);

	back_st_t            st_q, st_d;
	mode_t               mode_q, mode_d;
	logic                saved_frozen_q, saved_frozen_d;
	logic [AMOUNT_W-1:0] fwd_q, fwd_d;
	logic [AMOUNT_W-1:0] warp_rem_q, warp_rem_d;
	logic [AMOUNT_W-1:0] slow_f_q, slow_f_d;
	logic [AMOUNT_W-1:0] phase_q, phase_d;
	logic [AMOUNT_W-1:0] accel_q, accel_d;

	logic [MEAN_W-1:0]   mean_q, mean_d;
	logic [CW-1:0]       k_q, k_d;
	logic [SUM_W-1:0]    sum_q, sum_d;
	logic [AMOUNT_W-1:0] div_q, div_d;
	logic [AMOUNT_W-1:0] dvd_q, dvd_d;
	logic [AMOUNT_W-1:0] rem_q, rem_d;
	logic [3:0]          bit_q, bit_d;

	logic                res_valid_q, res_valid_d;
	logic [STEPS_W-1:0]  res_steps_q, res_steps_d;
	logic                res_acc_q, res_acc_d;
	logic                res_fin_q, res_fin_d;
	mode_t               res_mode_q, res_mode_d;
	logic                res_load;

	logic [AMOUNT_W-1:0] k_ext;
	logic [AMOUNT_W-1:0] take;
	logic [AMOUNT_W-1:0] left;
	logic [AMOUNT_W:0]   rem_sh;
	logic [AMOUNT_W:0]   r_inc;

	assign k_ext  = AMOUNT_W'(k_q);
	assign take   = (k_ext < warp_rem_q) ? k_ext : warp_rem_q;
	assign left   = warp_rem_q - take;
	assign rem_sh = {rem_q, dvd_q[AMOUNT_W-1]};
	assign r_inc  = {1'b0, rem_q} + {{AMOUNT_W{1'b0}}, 1'b1};

	always_comb begin
		st_d           = st_q;
		mode_d         = mode_q;
		saved_frozen_d = saved_frozen_q;
		fwd_d          = fwd_q;
		warp_rem_d     = warp_rem_q;
		slow_f_d       = slow_f_q;
		phase_d        = phase_q;
		accel_d        = accel_q;
		mean_d         = mean_q;
		k_d            = k_q;
		sum_d          = sum_q;
		div_d          = div_q;
		dvd_d          = dvd_q;
		rem_d          = rem_q;
		bit_d          = bit_q;
		res_steps_d    = res_steps_q;
		res_acc_d      = res_acc_q;
		res_fin_d      = res_fin_q;
		res_mode_d     = res_mode_q;
		res_load       = 1'b0;
		pop            = 1'b0;

		unique case (st_q)
			BK_IDLE: begin
				if (head.valid && !res_valid_q) begin
					pop         = 1'b1;
					res_steps_d = '0;
					res_acc_d   = 1'b0;
					res_fin_d   = 1'b0;
					res_load    = 1'b1;
					unique case (head.item.kind)
						KIND_TICK: begin
							res_acc_d = 1'b1;
							unique case (mode_q)
								MODE_NORMAL: res_steps_d = STEPS_W'(1);
								MODE_FROZEN: res_steps_d = '0;
								MODE_FORWARD: begin
									res_steps_d = fwd_q;
									res_fin_d   = 1'b1;
									accel_d     = AMOUNT_W'(1);
									fwd_d       = '0;
									slow_f_d    = AMOUNT_W'(1);
									mode_d      = MODE_NORMAL;
								end
								MODE_ACCEL: res_steps_d = accel_q;
								MODE_WARP: begin
									res_load = 1'b0;
									st_d     = BK_WARP;
									mean_d   = head.item.mean;
									k_d      = '0;
									sum_d    = SUM_W'(head.item.mean);
								end
								MODE_SLOW: begin
									res_load = 1'b0;
									st_d     = BK_MOD;
									div_d    = (slow_f_q == '0) ? AMOUNT_W'(1) : slow_f_q;
									dvd_d    = phase_q;
									rem_d    = '0;
									bit_d    = 4'd15;
								end
								default: res_steps_d = '0;
							endcase
						end
						KIND_FREEZE: begin
							if (mode_q != MODE_FROZEN) begin
								mode_d    = MODE_FROZEN;
								res_acc_d = 1'b1;
							end
						end
						KIND_RESET: begin
							accel_d   = AMOUNT_W'(1);
							fwd_d     = '0;
							slow_f_d  = AMOUNT_W'(1);
							mode_d    = MODE_NORMAL;
							res_acc_d = 1'b1;
						end
						KIND_FORWARD, KIND_WARP: begin
							if (mode_q == MODE_NORMAL || mode_q == MODE_FROZEN) begin
								saved_frozen_d = (mode_q == MODE_FROZEN);
								res_acc_d      = 1'b1;
								if (head.item.kind == KIND_FORWARD) begin
									fwd_d  = head.item.amount;
									mode_d = MODE_FORWARD;
								end else begin
									warp_rem_d = head.item.amount;
									mode_d     = MODE_WARP;
								end
							end
						end
						KIND_SLOW, KIND_ACCEL: begin
							if (mode_q == MODE_NORMAL) begin
								res_acc_d = 1'b1;
								if (head.item.kind == KIND_SLOW) begin
									slow_f_d = head.item.amount;
									mode_d   = MODE_SLOW;
								end else begin
									accel_d = head.item.amount;
									mode_d  = MODE_ACCEL;
								end
							end
						end
						default: res_acc_d = 1'b0;
					endcase
				end
			end
			BK_WARP: begin
				if (k_q < MAX_K && sum_q <= BUDGET) begin
					k_d   = k_q + CW'(1);
					sum_d = sum_q + SUM_W'(mean_q);
				end else begin
					warp_rem_d  = left;
					res_steps_d = take;
					res_acc_d   = 1'b1;
					res_fin_d   = (left == '0);
					if (left == '0) begin
						mode_d = saved_frozen_q ? MODE_FROZEN : MODE_NORMAL;
					end
					res_load = 1'b1;
					st_d     = BK_IDLE;
				end
			end
			BK_MOD: begin
				// restoring division, one quotient bit per cycle
				if (rem_sh >= {1'b0, div_q}) begin
					rem_d = AMOUNT_W'(rem_sh - {1'b0, div_q});
				end else begin
					rem_d = rem_sh[AMOUNT_W-1:0];
				end
				dvd_d = {dvd_q[AMOUNT_W-2:0], 1'b0};
				if (bit_q == 4'd0) begin
					st_d = BK_SLOW_END;
				end else begin
					bit_d = bit_q - 4'd1;
				end
			end
			BK_SLOW_END: begin
				res_steps_d = {{(STEPS_W-1){1'b0}}, (rem_q == '0)};
				res_acc_d   = 1'b1;
				res_fin_d   = 1'b0;
				phase_d     = (r_inc == {1'b0, div_q}) ? '0 : r_inc[AMOUNT_W-1:0];
				res_load    = 1'b1;
				st_d        = BK_IDLE;
			end
			default: st_d = BK_IDLE;
		endcase

		if (res_load) begin
			res_mode_d = mode_d;
		end
		res_valid_d = res_load || (res_valid_q && !results.ready);
	end

	assign results.valid        = res_valid_q;
	assign results.steps_to_run = res_steps_q;
	assign results.accepted     = res_acc_q;
	assign results.finished     = res_fin_q;
	assign results.mode_now     = res_mode_q;

	always_ff @(posedge clk) begin
		mean_q      <= mean_d;
		k_q         <= k_d;
		sum_q       <= sum_d;
		div_q       <= div_d;
		dvd_q       <= dvd_d;
		rem_q       <= rem_d;
		bit_q       <= bit_d;
		res_steps_q <= res_steps_d;
		res_acc_q   <= res_acc_d;
		res_fin_q   <= res_fin_d;
		res_mode_q  <= res_mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= BK_IDLE;
			mode_q         <= MODE_NORMAL;
			saved_frozen_q <= 1'b0;
			fwd_q          <= '0;
			warp_rem_q     <= '0;
			slow_f_q       <= AMOUNT_W'(1);
			phase_q        <= '0;
			accel_q        <= AMOUNT_W'(1);
			res_valid_q    <= 1'b0;
		end else begin
			st_q           <= st_d;
			mode_q         <= mode_d;
			saved_frozen_q <= saved_frozen_d;
			fwd_q          <= fwd_d;
			warp_rem_q     <= warp_rem_d;
			slow_f_q       <= slow_f_d;
			phase_q        <= phase_d;
			accel_q        <= accel_d;
			res_valid_q    <= res_valid_d;
		end
	end

endmodule
`default_nettype wire

>>> sv/tick_rate_mode_controller_core.sv
// tick rate mode controller top level: decode queue in front of the mode engine
// a command or a plain tick passes through its queue entry and then the result register
// a warp tick also runs the budget count loop before its result is loaded
// a slowed tick also runs the bit-serial phase modulo before its result is loaded
// a word is popped only once the single result register is empty; the queue holds two words
// reset: arst_n clears mode to normal, factors to 1, counts and queue to empty
`default_nettype none
module tick_rate_mode_controller_core
	import trmc_pkg::*;
#(
	parameter int MAX_WARP_STEPS = 8,
	parameter int WARP_BUDGET_US = 45000
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	trmc_in_if.sink    items,
	trmc_out_if.source results
);

	head_t head;
	logic  pop;

	trmc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.head   (head),
		.pop    (pop)
	);

	trmc_back #(
		.MAX_WARP_STEPS (MAX_WARP_STEPS),
		.WARP_BUDGET_US (WARP_BUDGET_US)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.results (results)
	);

endmodule
`default_nettype wire

>>> verif/tb.sv
// testbench for the tick rate mode controller: directed and random words checked by a scoreboard
`timescale 1ns / 1ps
module tb;
	import trmc_pkg::*;

	localparam int MAX_WARP  = 8;
	localparam int BUDGET_US = 45000;
	localparam logic [CMD_W-1:0] CMD_NONE = 3'd7;

	typedef struct packed {
		logic [STEPS_W-1:0] steps;
		logic               acc;
		logic               fin;
		logic [MODE_W-1:0]  mode;
	} tick_res_t;

	class tick_step_tracker;
		mode_t               mode;
		bit                  saved_frozen;
		logic [STEPS_W-1:0]  fwd_steps;
		logic [STEPS_W-1:0]  warp_left;
		logic [AMOUNT_W-1:0] slow_f;
		logic [AMOUNT_W-1:0] slow_ph;
		logic [AMOUNT_W-1:0] accel_f;
		tick_res_t           due[$];
		int                  fails;
		int                  shown;

		function new();
			mode         = MODE_NORMAL;
			saved_frozen = 1'b0;
			fwd_steps    = '0;
			warp_left    = '0;
			slow_f       = 16'd1;
			slow_ph      = '0;
			accel_f      = 16'd1;
			fails        = 0;
			shown        = 0;
		endfunction

		function void back_to_normal();
			accel_f   = 16'd1;
			fwd_steps = '0;
			slow_f    = 16'd1;
			mode      = MODE_NORMAL;
		endfunction

		task report(string msg);
			fails++;
			if (shown < 30) begin
				$display("mismatch at %0t: %s", $realtime, msg);
				shown++;
			end
		endtask

		function void take_item(logic [CMD_W-1:0] cmd, logic [AMOUNT_W-1:0] amt,
			logic [MEAN_W-1:0] mean);
			tick_res_t r;
			int        cap;
			int        f;
			r = '0;
			case (cmd)
				CMD_TICK: begin
					r.acc = 1'b1;
					case (mode)
						MODE_NORMAL: r.steps = 16'd1;
						MODE_WARP: begin
							cap = (mean == 0) ? MAX_WARP : BUDGET_US / int'(mean);
							if (cap > MAX_WARP)
								cap = MAX_WARP;
							if (cap > int'(warp_left))
								cap = int'(warp_left);
							r.steps   = STEPS_W'(cap);
							warp_left = warp_left - STEPS_W'(cap);
							if (warp_left == 0) begin
								r.fin = 1'b1;
								mode  = saved_frozen ? MODE_FROZEN : MODE_NORMAL;
							end
						end
						MODE_SLOW: begin
							f = (slow_f == 0) ? 1 : int'(slow_f);
							if (int'(slow_ph) % f == 0)
								r.steps = 16'd1;
							slow_ph = AMOUNT_W'((int'(slow_ph) + 1) % f);
						end
						MODE_FORWARD: begin
							r.steps = fwd_steps;
							r.fin   = 1'b1;
							back_to_normal();
						end
						MODE_ACCEL: r.steps = accel_f;
						default: ;
					endcase
				end
				CMD_FREEZE: begin
					if (mode != MODE_FROZEN) begin
						mode  = MODE_FROZEN;
						r.acc = 1'b1;
					end
				end
				CMD_RESET: begin
					back_to_normal();
					r.acc = 1'b1;
				end
				CMD_FORWARD, CMD_WARP: begin
					if (mode == MODE_NORMAL || mode == MODE_FROZEN) begin
						saved_frozen = (mode == MODE_FROZEN);
						if (cmd == CMD_FORWARD) begin
							fwd_steps = amt;
							mode      = MODE_FORWARD;
						end else begin
							warp_left = amt;
							mode      = MODE_WARP;
						end
						r.acc = 1'b1;
					end
				end
				CMD_SLOW, CMD_ACCEL: begin
					if (mode == MODE_NORMAL) begin
						if (cmd == CMD_SLOW) begin
							slow_f = amt;
							mode   = MODE_SLOW;
						end else begin
							accel_f = amt;
							mode    = MODE_ACCEL;
						end
						r.acc = 1'b1;
					end
				end
				default: ;
			endcase
			r.mode = mode;
			due = {due, r};
		endfunction

		task check_result(logic [STEPS_W-1:0] steps, logic acc, logic fin,
			logic [MODE_W-1:0] md);
			tick_res_t r;
			if (due.size() == 0) begin
				report("result word with nothing expected");
			end else begin
				r = due.pop_front();
				if (steps !== r.steps)
					report($sformatf("steps_to_run %0d, expected %0d", steps, r.steps));
				if (acc !== r.acc)
					report($sformatf("accepted %b, expected %b", acc, r.acc));
				if (fin !== r.fin)
					report($sformatf("finished %b, expected %b", fin, r.fin));
				if (md !== r.mode)
					report($sformatf("mode_now %0d, expected %0d", md, r.mode));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	trmc_in_if  items_ch ();
	trmc_out_if results_ch ();

	tick_rate_mode_controller_core #(
		.MAX_WARP_STEPS(MAX_WARP),
		.WARP_BUDGET_US(BUDGET_US)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_ch.sink),
		.results(results_ch.source)
	);

	tick_step_tracker board = new();
	bit idling    = 1'b1;
	int sent      = 0;
	int checked   = 0;
	int hold_left = 0;
	bit long_done = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// both channels are sampled mid-cycle, where inputs and outputs are settled
	always @(negedge clk) begin
		if (arst_n) begin
			if (items_ch.valid && items_ch.ready)
				board.take_item(items_ch.command, items_ch.amount, items_ch.mean_tick_us);
			if (results_ch.valid && results_ch.ready) begin
				checked++;
				board.check_result(results_ch.steps_to_run, results_ch.accepted,
					results_ch.finished, results_ch.mode_now);
			end
		end
	end

	// result side back-pressure, with one long hold-off to fill the block up
	initial begin
		results_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
				results_ch.ready <= 1'b0;
			end else if (!long_done && checked >= 100) begin
				long_done = 1'b1;
				hold_left = 299;
				results_ch.ready <= 1'b0;
			end else if (idling && $urandom_range(0, 4) == 0) begin
				hold_left = $urandom_range(0, 7);
				results_ch.ready <= 1'b0;
			end else begin
				results_ch.ready <= 1'b1;
			end
		end
	end

	task send_word(logic [CMD_W-1:0] cmd, logic [AMOUNT_W-1:0] amt, logic [MEAN_W-1:0] mean);
		bit fire;
		if (idling && $urandom_range(0, 3) == 0) begin
			items_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		items_ch.valid        <= 1'b1;
		items_ch.command      <= cmd;
		items_ch.amount       <= amt;
		items_ch.mean_tick_us <= mean;
		do begin
			@(negedge clk);
			fire = items_ch.ready;
			@(posedge clk);
		end while (!fire);
		if (cmd != CMD_NONE)
			sent++;
	endtask

	function logic [MEAN_W-1:0] rand_mean();
		int k;
		case ($urandom_range(0, 5))
			0: return '0;
			1: return MEAN_W'($urandom_range(1, 5625));
			2: begin
				k = $urandom_range(1, 9);
				return MEAN_W'(BUDGET_US / k + $urandom_range(0, 2) - 1);
			end
			3: return MEAN_W'($urandom_range(5626, 45001));
			4: return MEAN_W'($urandom_range(45001, 1048575));
			default: return MEAN_W'($urandom);
		endcase
	endfunction

	function logic [AMOUNT_W-1:0] rand_amount(logic [CMD_W-1:0] cmd);
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return (cmd == CMD_WARP) ? AMOUNT_W'($urandom_range(0, 40)) :
				AMOUNT_W'($urandom_range(0, 6));
		else if (r < 7)
			return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		return AMOUNT_W'($urandom);
	endfunction

	task run_sequence();
		logic [CMD_W-1:0] op;
		int               n;
		if ($urandom_range(0, 9) == 0) begin
			op = CMD_W'($urandom_range(0, 7));
			send_word(op, AMOUNT_W'($urandom), MEAN_W'($urandom));
		end else begin
			case ($urandom_range(0, 9))
				0: op = CMD_RESET;
				1: op = CMD_FREEZE;
				2, 3: op = CMD_FORWARD;
				4, 5, 6: op = CMD_WARP;
				7, 8: op = CMD_SLOW;
				default: op = CMD_ACCEL;
			endcase
			if ($urandom_range(0, 9) < 7) begin
				send_word(CMD_RESET, AMOUNT_W'($urandom), MEAN_W'($urandom));
				if ((op == CMD_FORWARD || op == CMD_WARP) && $urandom_range(0, 2) == 0)
					send_word(CMD_FREEZE, AMOUNT_W'($urandom), MEAN_W'($urandom));
			end
			send_word(op, rand_amount(op), rand_mean());
			n = (op == CMD_WARP || op == CMD_SLOW) ? $urandom_range(1, 10) : $urandom_range(0, 4);
			repeat (n)
				send_word(CMD_TICK, AMOUNT_W'($urandom), rand_mean());
		end
	endtask

	initial begin
		arst_n                = 1'b0;
		items_ch.valid        <= 1'b0;
		items_ch.command      <= CMD_TICK;
		items_ch.amount       <= '0;
		items_ch.mean_tick_us <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(CMD_TICK, 16'h0000, 20'h00000);
		send_word(CMD_NONE, 16'hFFFF, 20'hFFFFF);
		send_word(CMD_FREEZE, 16'h1234, 20'h00001);
		send_word(CMD_FREEZE, 16'h0000, 20'h00000);
		send_word(CMD_TICK, 16'hFFFF, 20'hFFFFF);
		send_word(CMD_WARP, 16'd0, 20'd0);
		send_word(CMD_TICK, 16'd0, 20'hFFFFF);
		send_word(CMD_FORWARD, 16'hFFFF, 20'd0);
		send_word(CMD_TICK, 16'd0, 20'd100);
		send_word(CMD_SLOW, 16'd0, 20'd0);
		send_word(CMD_TICK, 16'd0, 20'd0);
		send_word(CMD_ACCEL, 16'd5, 20'd0);
		send_word(CMD_RESET, 16'd0, 20'd0);
		send_word(CMD_SLOW, 16'd3, 20'd0);
		repeat (3)
			send_word(CMD_TICK, 16'd0, 20'd0);
		send_word(CMD_RESET, 16'd0, 20'd0);
		send_word(CMD_ACCEL, 16'd0, 20'd0);
		send_word(CMD_TICK, 16'd0, 20'd0);
		send_word(CMD_FORWARD, 16'd7, 20'd0);
		send_word(CMD_RESET, 16'd0, 20'd0);
		send_word(CMD_WARP, 16'd20, 20'd0);
		send_word(CMD_TICK, 16'd0, 20'd0);
		send_word(CMD_TICK, 16'd0, 20'd45000);
		send_word(CMD_TICK, 16'd0, 20'd5626);
		send_word(CMD_TICK, 16'd0, 20'd5625);

		while (sent < 1050) begin
			if (sent >= 900)
				idling = 1'b0;
			run_sequence();
		end
		items_ch.valid <= 1'b0;

		while (board.due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (board.fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
